FILE: hdl/pci_pkg.sv
// ----------------------------------------------------------------------------
// pci_pkg: shared types for polygon_centroid_inflate
// Payload structs, register indexes, controller command/status structs.
// ----------------------------------------------------------------------------
package pci_pkg;

    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_PUSH_DISTANCE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_OFFSET_X      = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_OFFSET_Y      = 2'd2;

    localparam logic signed [16:0] PushReset = 17'sd197;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               last_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic               end_of_polygon;
        logic               overflowed;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;       // store accepted vertex
        logic div_start;  // start centroid divide
        logic rd;         // read vertex at emit index
        logic vtx_start;  // start per-vertex inflate
        logic emit;       // drive result
        logic clear;      // end of polygon
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic vtx_done;
        logic last_idx;   // emit index is last stored vertex
        logic empty;
    } t_status;

endpackage

FILE: hdl/polygon_centroid_inflate.sv
// ----------------------------------------------------------------------------
// polygon_centroid_inflate: convex polygon centroid and outward push
// Vertices load at one per cycle while busy is low. After the vertex marked
// last, a bit-serial centroid divide runs, then each stored vertex goes
// through read, setup, a 32-step square root, a 49-step push divide and emit,
// with a halving step added when a coordinate difference needs halving; a
// vertex sitting on the centroid skips the root and the divide.
// Results appear one per o_valid pulse and cannot be stalled; busy stays high
// until the final result is out, then drops for the next polygon.
// ----------------------------------------------------------------------------
module polygon_centroid_inflate #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pci_pkg::t_in_item             i_item,
    input  logic                          i_cfg_we,
    input  logic [pci_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [pci_pkg::CfgDataW-1:0]  i_cfg_data,
    output logic                          o_valid,
    output pci_pkg::t_out_item            o_item
);
    import pci_pkg::*;

    t_cmd    cmd;
    t_status sts;

    pci_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_last(i_item.last_vertex), .i_sts(sts), .o_cmd(cmd),
        .o_busy(busy), .o_strobe(o_valid)
    );

    pci_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .i_item(i_item),
        .i_cmd(cmd), .o_sts(sts), .o_item(o_item)
    );

endmodule

FILE: hdl/pci_datapath.sv
// ----------------------------------------------------------------------------
// pci_datapath: vertex store, centroid divider, sqrt and push dividers
// All long operations are bit-serial, one bit per cycle.
// ----------------------------------------------------------------------------
module pci_datapath #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pci_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [pci_pkg::CfgDataW-1:0] i_cfg_data,
    input  pci_pkg::t_in_item          i_item,
    input  pci_pkg::t_cmd              i_cmd,
    output pci_pkg::t_status           o_sts,
    output pci_pkg::t_out_item         o_item
);
    import pci_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic signed [16:0] r_push;
    logic [31:0] r_offx, r_offy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= PushReset;
            r_offx <= '0;
            r_offy <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PUSH_DISTANCE: r_push <= i_cfg_data[16:0];
                REG_OFFSET_X:      r_offx <= i_cfg_data;
                REG_OFFSET_Y:      r_offy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- store ----------------
    logic [127:0] mem [MAX_VERTICES];
    logic [127:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_ridx;
    logic signed [38:0] r_sumx, r_sumy;
    logic r_drop;
    logic [31:0] sx, sy;

    assign sx = i_item.vertex_x + r_offx;
    assign sy = i_item.vertex_y + r_offy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_cnt < CW'(MAX_VERTICES))
            mem[r_cnt[AW-1:0]] <= {sx, sy, i_item.tex_u, i_item.tex_v};
        if (i_cmd.rd) r_rd <= mem[r_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_sumx <= '0; r_sumy <= '0; r_drop <= 1'b0; r_ridx <= '0;
        end else if (i_cmd.clear) begin
            r_cnt <= '0; r_sumx <= '0; r_sumy <= '0; r_drop <= 1'b0; r_ridx <= '0;
        end else begin
            if (i_cmd.load) begin
                if (r_cnt < CW'(MAX_VERTICES)) begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_sumx <= r_sumx + 39'(signed'(sx));
                    r_sumy <= r_sumy + 39'(signed'(sy));
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.emit) r_ridx <= r_ridx + 1'b1;
        end
    end

    assign o_sts.empty = (r_cnt == '0);
    assign o_sts.last_idx = (CW'(r_ridx) + 1'b1 == r_cnt);

    // ---------------- centroid divide (restoring, both axes) ----------------
    logic [38:0] r_qx, r_qy;
    logic [CW-1:0] r_remx, r_remy;
    logic [5:0] r_dcnt;
    logic r_dbusy, r_nsx, r_nsy;
    logic signed [31:0] r_cx, r_cy;
    logic [CW:0] tx, ty;

    assign tx = {r_remx, r_qx[38]};
    assign ty = {r_remy, r_qy[38]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0; r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1; r_dcnt <= 6'd39;
            r_nsx <= r_sumx[38]; r_nsy <= r_sumy[38];
            r_qx <= r_sumx[38] ? -r_sumx : r_sumx;
            r_qy <= r_sumy[38] ? -r_sumy : r_sumy;
            r_remx <= '0; r_remy <= '0;
        end else if (r_dbusy) begin
            if (r_dcnt == '0) begin
                r_dbusy <= 1'b0;
                r_cx <= r_nsx ? -r_qx[31:0] : r_qx[31:0];
                r_cy <= r_nsy ? -r_qy[31:0] : r_qy[31:0];
            end else begin
                r_dcnt <= r_dcnt - 1'b1;
                if (tx >= {1'b0, r_cnt}) begin
                    r_remx <= CW'(tx - {1'b0, r_cnt}); r_qx <= {r_qx[37:0], 1'b1};
                end else begin
                    r_remx <= tx[CW-1:0]; r_qx <= {r_qx[37:0], 1'b0};
                end
                if (ty >= {1'b0, r_cnt}) begin
                    r_remy <= CW'(ty - {1'b0, r_cnt}); r_qy <= {r_qy[37:0], 1'b1};
                end else begin
                    r_remy <= ty[CW-1:0]; r_qy <= {r_qy[37:0], 1'b0};
                end
            end
        end
    end
    assign o_sts.div_done = r_dbusy && r_dcnt == '0;

    // ---------------- per-vertex inflate ----------------
    // phases: diff, norm, square x, square y, sqrt, divide, output
    typedef enum logic [6:0] {
        V_IDLE = 7'b0000001, V_DIFF = 7'b0000010, V_NORM = 7'b0000100,
        V_SQX  = 7'b0001000, V_SQY  = 7'b0010000, V_SQRT = 7'b0100000,
        V_DIV  = 7'b1000000
    } t_vst;
    t_vst r_vs;

    logic signed [32:0] r_dx, r_dy;
    logic [32:0] r_ax, r_ay;
    logic r_ngx, r_ngy;
    logic [63:0] r_sq, r_rem;
    logic [31:0] r_root;
    logic [5:0] r_it;
    logic [48:0] r_nx, r_ny;       // ad*ax dividend shifting
    logic [31:0] r_rx, r_ry;       // remainders (< len < 2^32)
    logic [47:0] r_fx, r_fy;       // quotients
    logic [31:0] r_ox, r_oy;
    logic [16:0] ad;
    logic [65:0] sq_t;
    logic [65:0] sq_trial;
    logic [32:0] dvx, dvy;

    assign ad = r_push[16] ? 17'(-r_push) : r_push;
    assign sq_t = {r_rem, r_sq[63:62]};
    assign sq_trial = {32'd0, r_root, 2'b01};
    assign dvx = {r_rx, r_nx[48]};
    assign dvy = {r_ry, r_ny[48]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= V_IDLE;
        end else begin
            unique case (r_vs)
                V_IDLE: if (i_cmd.vtx_start) r_vs <= V_DIFF;
                V_DIFF: begin
                    r_dx <= 33'(signed'(r_rd[127:96])) - 33'(r_cx);
                    r_dy <= 33'(signed'(r_rd[95:64])) - 33'(r_cy);
                    r_ox <= r_rd[127:96]; r_oy <= r_rd[95:64];
                    r_vs <= V_NORM;
                end
                V_NORM: begin
                    r_ngx <= r_dx[32]; r_ngy <= r_dy[32];
                    if (r_dx == '0 && r_dy == '0) begin
                        r_vs <= V_IDLE;
                    end else begin
                        r_ax <= r_dx[32] ? -r_dx : r_dx;
                        r_ay <= r_dy[32] ? -r_dy : r_dy;
                        r_vs <= V_SQX;
                    end
                end
                V_SQX: begin
                    if (r_ax[32:31] != 2'b00 || r_ay[32:31] != 2'b00) begin
                        r_ax <= r_ax >> 1; r_ay <= r_ay >> 1;
                    end else begin
                        r_sq <= r_ax[30:0] * r_ax[30:0];
                        r_vs <= V_SQY;
                    end
                end
                V_SQY: begin
                    r_sq <= r_sq + 64'(r_ay[30:0] * r_ay[30:0]);
                    r_rem <= '0; r_root <= '0; r_it <= 6'd32;
                    r_vs <= V_SQRT;
                end
                V_SQRT: begin
                    if (r_it == '0) begin
                        r_nx <= {49'(ad * r_ax[31:0])};
                        r_ny <= {49'(ad * r_ay[31:0])};
                        r_rx <= '0; r_ry <= '0; r_it <= 6'd49;
                        if (r_root == '0) r_vs <= V_IDLE;
                        else r_vs <= V_DIV;
                    end else begin
                        r_it <= r_it - 1'b1;
                        r_sq <= {r_sq[61:0], 2'b00};
                        if (sq_t >= sq_trial) begin
                            r_rem <= 64'(sq_t - sq_trial);
                            r_root <= {r_root[30:0], 1'b1};
                        end else begin
                            r_rem <= sq_t[63:0];
                            r_root <= {r_root[30:0], 1'b0};
                        end
                    end
                end
                V_DIV: begin
                    if (r_it == '0) begin
                        r_ox <= (r_push[16] != r_ngx) ? r_ox - r_fx[31:0]
                                                      : r_ox + r_fx[31:0];
                        r_oy <= (r_push[16] != r_ngy) ? r_oy - r_fy[31:0]
                                                      : r_oy + r_fy[31:0];
                        r_vs <= V_IDLE;
                    end else begin
                        r_it <= r_it - 1'b1;
                        r_nx <= {r_nx[47:0], 1'b0};
                        r_ny <= {r_ny[47:0], 1'b0};
                        if (dvx >= {1'b0, r_root}) begin
                            r_rx <= 32'(dvx - {1'b0, r_root}); r_fx <= {r_fx[46:0], 1'b1};
                        end else begin
                            r_rx <= dvx[31:0]; r_fx <= {r_fx[46:0], 1'b0};
                        end
                        if (dvy >= {1'b0, r_root}) begin
                            r_ry <= 32'(dvy - {1'b0, r_root}); r_fy <= {r_fy[46:0], 1'b1};
                        end else begin
                            r_ry <= dvy[31:0]; r_fy <= {r_fy[46:0], 1'b0};
                        end
                    end
                end
                default: r_vs <= V_IDLE;
            endcase
        end
    end

    assign o_sts.vtx_done = (r_vs == V_NORM && r_dx == '0 && r_dy == '0)
                          || (r_vs == V_SQRT && r_it == '0 && r_root == '0)
                          || (r_vs == V_DIV && r_it == '0);

    // result register, one-cycle strobe is the controller's emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_item.out_x <= r_ox;
            o_item.out_y <= r_oy;
            o_item.out_u <= r_rd[63:32];
            o_item.out_v <= r_rd[31:0];
            o_item.end_of_polygon <= o_sts.last_idx;
            o_item.overflowed <= r_drop;
        end
    end

endmodule

FILE: hdl/pci_ctrl.sv
// ----------------------------------------------------------------------------
// pci_ctrl: sequencer for load, centroid divide and per-vertex emit
// ----------------------------------------------------------------------------
module pci_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_last,
    input  pci_pkg::t_status  i_sts,
    output pci_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_strobe
);
    import pci_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_DIV  = 6'b000010, S_READ = 6'b000100,
        S_VTX  = 6'b001000, S_WAIT = 6'b010000, S_EMIT = 6'b100000
    } t_state;
    t_state r_st, n_st;
    logic r_strobe, r_vstart;
    // clear in the cycle after the final emit so the result register sees the flags
    logic r_clr;

    always_comb begin
        n_st = r_st;
        o_cmd = '0;
        unique case (r_st)
            S_IDLE: if (i_start && !r_clr) begin
                o_cmd.load = 1'b1;
                if (i_last) n_st = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b0;
                if (i_sts.div_done) n_st = i_sts.empty ? S_IDLE : S_READ;
                if (i_sts.div_done && i_sts.empty) o_cmd.clear = 1'b1;
            end
            S_READ: begin o_cmd.rd = 1'b1; n_st = S_VTX; end
            S_VTX:  begin o_cmd.vtx_start = 1'b1; n_st = S_WAIT; end
            S_WAIT: if (i_sts.vtx_done) n_st = S_EMIT;
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.last_idx) n_st = S_IDLE;
                else n_st = S_READ;
            end
            default: n_st = S_IDLE;
        endcase
        if (r_vstart) o_cmd.div_start = 1'b1;
        if (r_clr) o_cmd.clear = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_strobe <= 1'b0; r_vstart <= 1'b0;
        end else begin
            r_st <= n_st;
            r_strobe <= o_cmd.emit;
            r_vstart <= (r_st == S_IDLE) && i_start && !r_clr && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= 1'b0;
        else r_clr <= (r_st == S_EMIT) && i_sts.last_idx;
    end

    assign o_busy = (r_st != S_IDLE) || r_clr;
    assign o_strobe = r_strobe;

endmodule
